>>> hdl/gemm_pkg.sv
// Shared types and constants for the matrix multiply-accumulate block.
package gemm_pkg;

  localparam int unsigned ReqW = 3;
  localparam int unsigned IdxW = 4;
  localparam int unsigned ValW = 16;
  localparam int unsigned DimW = 5;
  localparam int unsigned AccW = 48;

  localparam logic [ReqW-1:0] REQ_WR_A    = 3'd0;
  localparam logic [ReqW-1:0] REQ_WR_B    = 3'd1;
  localparam logic [ReqW-1:0] REQ_WR_C    = 3'd2;
  localparam logic [ReqW-1:0] REQ_COMPUTE = 3'd3;
  localparam logic [ReqW-1:0] REQ_RD_C    = 3'd4;

  localparam logic [2:0] REG_TRANS_A = 3'd0;
  localparam logic [2:0] REG_TRANS_B = 3'd1;
  localparam logic [2:0] REG_ROWS_M  = 3'd2;
  localparam logic [2:0] REG_COLS_N  = 3'd3;
  localparam logic [2:0] REG_INNER_K = 3'd4;
  localparam logic [2:0] REG_ALPHA   = 3'd5;
  localparam logic [2:0] REG_BETA    = 3'd6;

  typedef struct packed {
    logic [ReqW-1:0]        req_type;
    logic [IdxW-1:0]        row_index;
    logic [IdxW-1:0]        col_index;
    logic signed [ValW-1:0] element_value;
  } gemm_in_t;

  typedef struct packed {
    logic [ReqW-1:0]        ack_kind;
    logic signed [ValW-1:0] read_value;
  } gemm_out_t;

  // control handed down the cell chain with each operand pair
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } gemm_tag_t;

endpackage

>>> hdl/general_matrix_multiply_accumulate.sv
// Top level: matrix multiply-accumulate with element stores and APB config.
// Usage:
//  Input channel (in_valid/in_stall, payload in_data) carries one request:
//  write A, write B, write C, compute, or read C. Each request yields one
//  output transaction (out_valid/out_stall, out_data) echoing the request
//  type; reads carry the stored C element, other requests carry zero.
//  Writes, unknown requests and out-of-range reads give their result in the
//  cycle after acceptance and can follow back to back while the output is
//  not stalled; an in-range read passes store read, register and output.
//  A compute runs M*N result elements; each element streams K operand pairs
//  through a two-cell chain (multiply, accumulate), waits in S_DRAIN for the
//  chain to drain, then scales (alpha*sum, beta*C) and writes back, with a
//  sum of zero when K is zero; when M or N is zero, no element is written.
//  One request is in work at a time; the output register holds a result
//  while out_stall is high, and the input stalls until that result leaves.
//  Reset clears control and config (M=N=K=16, alpha=beta=1.0, no
//  transpose); stores are undefined until written. The user must write
//  configuration through the APB port only while idle; this is not checked.
module general_matrix_multiply_accumulate import gemm_pkg::*; #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  gemm_in_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output gemm_out_t       out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int unsigned AW = $clog2(MAX_DIM*MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM);
  localparam int unsigned KW = $clog2(MAX_DIM+1);

  logic              trans_a, trans_b;
  logic [DimW-1:0]   rows_m, cols_n, inner_k;
  logic signed [15:0] alpha, beta;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      trans_a <= 1'b0; trans_b <= 1'b0;
      rows_m <= 5'd16; cols_n <= 5'd16; inner_k <= 5'd16;
      alpha <= 16'sd256; beta <= 16'sd256;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_TRANS_A: trans_a <= pwdata[0];
        REG_TRANS_B: trans_b <= pwdata[0];
        REG_ROWS_M:  rows_m  <= pwdata[4:0];
        REG_COLS_N:  cols_n  <= pwdata[4:0];
        REG_INNER_K: inner_k <= pwdata[4:0];
        REG_ALPHA:   alpha   <= pwdata[15:0];
        REG_BETA:    beta    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_TRANS_A: prdata = {31'd0, trans_a};
      REG_TRANS_B: prdata = {31'd0, trans_b};
      REG_ROWS_M:  prdata = {27'd0, rows_m};
      REG_COLS_N:  prdata = {27'd0, cols_n};
      REG_INNER_K: prdata = {27'd0, inner_k};
      REG_ALPHA:   prdata = {16'd0, alpha};
      REG_BETA:    prdata = {16'd0, beta};
      default:     prdata = '0;
    endcase
  end

  function automatic logic [KW-1:0] clampd(input logic [DimW-1:0] d);
    clampd = (32'(d) > MAX_DIM) ? KW'(MAX_DIM) : KW'(d);
  endfunction

  // ---------------- stores ----------------
  logic [15:0] a_mem [MAX_DIM*MAX_DIM];
  logic [15:0] b_mem [MAX_DIM*MAX_DIM];
  logic [15:0] c_mem [MAX_DIM*MAX_DIM];
  logic [AW-1:0] a_ra, b_ra, c_ra, c_wa;
  logic [15:0]   a_rd, b_rd, c_rd, c_wd;
  logic          a_we, b_we, c_we;
  logic [AW-1:0] w_addr;
  logic [15:0]   w_data;

  always_ff @(posedge clk) begin
    if (a_we) a_mem[w_addr] <= w_data;
    if (b_we) b_mem[w_addr] <= w_data;
    if (c_we) c_mem[c_wa] <= c_wd;
    a_rd <= a_mem[a_ra];
    b_rd <= b_mem[b_ra];
    c_rd <= c_mem[c_ra];
  end

  // ---------------- control ----------------
  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_RDOUT, S_STREAM, S_DRAIN, S_SCALE, S_SUM, S_WB
  } state_t;
  state_t state;

  logic [ReqW-1:0] req;
  logic [DW-1:0]   ci, cj, ck;
  logic [KW-1:0]   m_c, n_c, k_c;
  logic [2:0]      drain;
  logic            in_range;
  logic [AW-1:0]   in_addr;
  logic            out_full;
  logic            accept_in;

  assign in_range = (32'(in_data.row_index) < MAX_DIM) && (32'(in_data.col_index) < MAX_DIM);
  assign in_addr = AW'(32'(in_data.row_index) * MAX_DIM + 32'(in_data.col_index));
  assign in_stall = (state != S_IDLE) || (out_full && out_stall);
  assign accept_in = in_valid && !in_stall;
  assign w_addr = in_addr;
  assign w_data = in_data.element_value;
  assign a_we = accept_in && in_range && in_data.req_type == REQ_WR_A;
  assign b_we = accept_in && in_range && in_data.req_type == REQ_WR_B;

  // chain feed
  gemm_tag_t t0, t1, t2;
  logic signed [ValW-1:0] a1, b1, a2, b2;
  logic signed [AccW-1:0] p1, s2;
  logic first_q, last_q, feed_q;

  always_comb begin
    a_ra = trans_a ? AW'(32'(ck) * MAX_DIM + 32'(ci)) : AW'(32'(ci) * MAX_DIM + 32'(ck));
    b_ra = trans_b ? AW'(32'(cj) * MAX_DIM + 32'(ck)) : AW'(32'(ck) * MAX_DIM + 32'(cj));
    c_ra = (state == S_IDLE) ? in_addr : AW'(32'(ci) * MAX_DIM + 32'(cj));
  end

  // the store read is registered, so the tag is registered to match
  assign t0 = '{valid: feed_q, first: first_q, last: last_q};

  gemm_mac_cell #(.STAGE(0)) u_mul (
    .clk, .rst, .tag_in(t0), .a_in(a_rd), .b_in(b_rd), .acc_in('0),
    .tag_out(t1), .a_out(a1), .b_out(b1), .acc_out(p1)
  );
  gemm_mac_cell #(.STAGE(1)) u_acc (
    .clk, .rst, .tag_in(t1), .a_in(a1), .b_in(b1), .acc_in(p1),
    .tag_out(t2), .a_out(a2), .b_out(b2), .acc_out(s2)
  );

  logic signed [AccW+16-1:0] tot, tot_next;
  logic signed [15:0]        rnd;
  logic signed [AccW+16-1:0] tr;

  always_comb begin
    tr = (tot + 64'sd32768) >>> 16;
    if (tr > 64'sd32767)       rnd = 16'sh7fff;
    else if (tr < -64'sd32768) rnd = 16'sh8000;
    else                       rnd = tr[15:0];
  end

  assign c_we = (state == S_WB) || (accept_in && in_range && in_data.req_type == REQ_WR_C);
  assign c_wa = (state == S_WB) ? AW'(32'(ci) * MAX_DIM + 32'(cj)) : in_addr;
  assign c_wd = (state == S_WB) ? rnd : in_data.element_value;

  always_comb begin
    tot_next = tot;
    if (state == S_SCALE) tot_next = 64'(s2) * 64'(alpha);
    else if (state == S_SUM) tot_next = tot + ((64'(beta) * 64'($signed(c_rd))) <<< 8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      out_full <= 1'b0;
      feed_q <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
        out_full  <= 1'b0;
      end
      feed_q <= 1'b0;
      unique case (state)
        S_IDLE: if (accept_in) begin
          req <= in_data.req_type;
          m_c <= clampd(rows_m); n_c <= clampd(cols_n); k_c <= clampd(inner_k);
          // a read keeps its element address in ci/cj for the store read
          ci <= (in_data.req_type == REQ_RD_C) ? DW'(in_data.row_index) : '0;
          cj <= (in_data.req_type == REQ_RD_C) ? DW'(in_data.col_index) : '0;
          ck <= '0;
          if (in_data.req_type == REQ_COMPUTE) begin
            if (clampd(rows_m) == 0 || clampd(cols_n) == 0) state <= S_RDOUT;
            else state <= S_STREAM;
          end else if (in_data.req_type == REQ_RD_C && in_range) begin
            state <= S_RD;
          end else begin
            out_valid <= 1'b1; out_full <= 1'b1;
            out_data.ack_kind <= in_data.req_type;
            out_data.read_value <= '0;
          end
        end
        S_RD: state <= S_RDOUT;
        S_RDOUT: if (!out_full || !out_stall) begin
          out_valid <= 1'b1; out_full <= 1'b1;
          out_data.ack_kind <= req;
          out_data.read_value <= (req == REQ_RD_C) ? $signed(c_rd) : '0;
          state <= S_IDLE;
        end
        S_STREAM: begin
          if (k_c != 0) begin
            feed_q <= 1'b1;
            first_q <= (ck == 0);
            last_q <= (32'(ck) == 32'(k_c) - 1);
          end
          if (k_c == 0 || 32'(ck) == 32'(k_c) - 1) begin
            state <= S_DRAIN;
            drain <= 3'd3;
          end else begin
            ck <= ck + 1'b1;
          end
        end
        S_DRAIN: begin
          drain <= drain - 1'b1;
          if (drain == 0) state <= S_SCALE;
        end
        S_SCALE: state <= S_SUM;
        S_SUM: state <= S_WB;
        S_WB: begin
          ck <= '0;
          if (32'(cj) == 32'(n_c) - 1) begin
            cj <= '0;
            if (32'(ci) == 32'(m_c) - 1) state <= S_RDOUT;
            else begin ci <= ci + 1'b1; state <= S_STREAM; end
          end else begin
            cj <= cj + 1'b1; state <= S_STREAM;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // zero sum when K is zero
  logic k_zero;
  assign k_zero = (k_c == 0);
  always_ff @(posedge clk) begin
    tot <= (state == S_SCALE && k_zero) ? '0 : tot_next;
  end

  // ---------------- assertions ----------------
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("output lost under stall");
  a_wb_scope: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> (req == REQ_COMPUTE)) else $error("writeback outside compute");

endmodule

>>> hdl/gemm_mac_cell.sv
// One cell of the chain: a registered stage of the multiply-accumulate pipe.
module gemm_mac_cell import gemm_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gemm_tag_t              tag_in,
  input  logic signed [ValW-1:0] a_in,
  input  logic signed [ValW-1:0] b_in,
  input  logic signed [AccW-1:0] acc_in,
  output gemm_tag_t              tag_out,
  output logic signed [ValW-1:0] a_out,
  output logic signed [ValW-1:0] b_out,
  output logic signed [AccW-1:0] acc_out
);

  logic signed [2*ValW-1:0] prod;
  logic signed [AccW-1:0]   acc_next;

  // stage 0 multiplies, stage 1 accumulates and holds between elements
  always_comb begin
    prod     = a_in * b_in;
    acc_next = acc_out;
    if (STAGE == 0) begin
      acc_next = AccW'(prod);
    end else if (tag_in.valid) begin
      acc_next = tag_in.first ? acc_in : acc_out + acc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    a_out   <= a_in;
    b_out   <= b_in;
    acc_out <= acc_next;
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the matrix multiply-accumulate block.
`timescale 1ns / 1ps

module testbench;
  import gemm_pkg::*;

  localparam logic [ReqW-1:0] REQ_UNUSED_5 = 3'd5;
  localparam logic [ReqW-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [ReqW-1:0] REQ_UNUSED_7 = 3'd7;
  localparam int unsigned ST_A = 0;
  localparam int unsigned ST_B = 1;
  localparam int unsigned ST_C = 2;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned ITEMS_PER_PHASE = 60;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  gemm_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  gemm_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  general_matrix_multiply_accumulate dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    bit          ta;
    bit          tb;
    logic [4:0]  m;
    logic [4:0]  n;
    logic [4:0]  k;
    logic [15:0] alpha;
    logic [15:0] beta;
  } gemm_cfg_t;

  typedef struct {
    gemm_in_t  req;
    bit        typed;
    gemm_out_t ack;
  } stim_row_t;

  // shadow of the block
  logic [15:0] a_mem [256];
  logic [15:0] b_mem [256];
  logic [15:0] c_mem [256];
  bit          a_ok [256];
  bit          b_ok [256];
  bit          c_ok [256];
  gemm_cfg_t   cfg;

  gemm_out_t   pending_acks [$];
  int unsigned errors = 0;
  int unsigned sent_count = 0;
  int          burst_left = 8;
  bit          hold_done = 0;

  function automatic int dim(logic [4:0] d);
    return (d > 16) ? 16 : int'(d);
  endfunction

  function automatic logic [15:0] round_q88(longint x);
    longint q;
    q = (x + 32768) >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic int a_addr(int i, int k);
    return cfg.ta ? k * 16 + i : i * 16 + k;
  endfunction

  function automatic int b_addr(int k, int j);
    return cfg.tb ? j * 16 + k : k * 16 + j;
  endfunction

  function automatic void run_gemm();
    longint acc, av, bv, cv, al, be;
    al = $signed(cfg.alpha);
    be = $signed(cfg.beta);
    for (int i = 0; i < dim(cfg.m); i++) begin
      for (int j = 0; j < dim(cfg.n); j++) begin
        acc = 0;
        for (int k = 0; k < dim(cfg.k); k++) begin
          av = $signed(a_mem[a_addr(i, k)]);
          bv = $signed(b_mem[b_addr(k, j)]);
          acc += av * bv;
        end
        cv = $signed(c_mem[i * 16 + j]);
        c_mem[i * 16 + j] = round_q88(al * acc + be * cv * 256);
      end
    end
  endfunction

  function automatic gemm_out_t gemm_predict(gemm_in_t t);
    gemm_out_t r;
    int idx;
    idx = int'(t.row_index) * 16 + int'(t.col_index);
    r.ack_kind = t.req_type;
    r.read_value = '0;
    case (t.req_type)
      REQ_WR_A: begin a_mem[idx] = t.element_value; a_ok[idx] = 1; end
      REQ_WR_B: begin b_mem[idx] = t.element_value; b_ok[idx] = 1; end
      REQ_WR_C: begin c_mem[idx] = t.element_value; c_ok[idx] = 1; end
      REQ_COMPUTE: run_gemm();
      REQ_RD_C: r.read_value = c_mem[idx];
      default: ;
    endcase
    return r;
  endfunction

  // first entry a compute would read that was never written
  function automatic bit find_gap(output int st, output int idx);
    for (int i = 0; i < dim(cfg.m); i++)
      for (int k = 0; k < dim(cfg.k); k++)
        if (!a_ok[a_addr(i, k)]) begin st = ST_A; idx = a_addr(i, k); return 1; end
    for (int k = 0; k < dim(cfg.k); k++)
      for (int j = 0; j < dim(cfg.n); j++)
        if (!b_ok[b_addr(k, j)]) begin st = ST_B; idx = b_addr(k, j); return 1; end
    for (int i = 0; i < dim(cfg.m); i++)
      for (int j = 0; j < dim(cfg.n); j++)
        if (!c_ok[i * 16 + j]) begin st = ST_C; idx = i * 16 + j; return 1; end
    st = ST_A;
    idx = 0;
    return 0;
  endfunction

  function automatic gemm_in_t mk_req(logic [2:0] kind, int row, int col, logic [15:0] v);
    gemm_in_t t;
    t.req_type = kind;
    t.row_index = row[3:0];
    t.col_index = col[3:0];
    t.element_value = v;
    return t;
  endfunction

  function automatic int pick_index();
    if ($urandom_range(0, 99) < 70) return $urandom_range(0, 4);
    return $urandom_range(0, 15);
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic send_req(gemm_in_t t, bit typed, gemm_out_t ack);
    gemm_out_t p;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    p = gemm_predict(t);
    pending_acks.insert(pending_acks.size(), typed ? ack : p);
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_cfg(gemm_cfg_t c);
    apb_write(REG_TRANS_A, {31'd0, c.ta});
    apb_write(REG_TRANS_B, {31'd0, c.tb});
    apb_write(REG_ROWS_M, {27'd0, c.m});
    apb_write(REG_COLS_N, {27'd0, c.n});
    apb_write(REG_INNER_K, {27'd0, c.k});
    apb_write(REG_ALPHA, {16'd0, c.alpha});
    apb_write(REG_BETA, {16'd0, c.beta});
    cfg = c;
  endtask

  function automatic gemm_in_t gap_or_write(logic [2:0] kind);
    int st, idx;
    if (find_gap(st, idx))
      return mk_req(st[2:0], idx / 16, idx % 16, 16'($urandom()));
    return mk_req(kind, pick_index(), pick_index(), 16'($urandom()));
  endfunction

  task automatic random_item();
    gemm_in_t t;
    gemm_out_t none;
    int r, st, idx, row, col;
    bit found;
    none = '0;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      t = mk_req(3'($urandom_range(0, 2)), pick_index(), pick_index(), 16'($urandom()));
    end else if (r < 55) begin
      if (find_gap(st, idx)) t = mk_req(st[2:0], idx / 16, idx % 16, 16'($urandom()));
      else t = mk_req(REQ_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                      16'($urandom()));
    end else if (r < 80) begin
      found = 0;
      for (int i = 0; i < 8 && !found; i++) begin
        row = pick_index();
        col = pick_index();
        found = c_ok[row * 16 + col];
      end
      if (found) t = mk_req(REQ_RD_C, row, col, 16'($urandom()));
      else t = mk_req(REQ_WR_C, row, col, 16'($urandom()));
    end else if (r < 90) begin
      t = mk_req(3'($urandom_range(5, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
                 16'($urandom()));
    end else begin
      t = gap_or_write(3'($urandom_range(0, 2)));
    end
    send_req(t, 1'b0, none);
  endtask

  // output checker
  always @(posedge clk) begin
    gemm_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_acks.size() == 0) begin
        $error("unexpected transaction: ack_kind %0d read_value %0d",
               out_data.ack_kind, out_data.read_value);
        errors++;
      end else begin
        e = pending_acks.pop_front();
        if (out_data.ack_kind !== e.ack_kind) begin
          $error("ack_kind: expected %0d actual %0d", e.ack_kind, out_data.ack_kind);
          errors++;
        end
        if (out_data.read_value !== e.read_value) begin
          $error("read_value: expected %0d actual %0d", e.read_value, out_data.read_value);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode, stretch;
    out_stall = 1'b0;
    mode = 0;
    stretch = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= 400) begin
        hold_done = 1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 2);
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          default: out_stall <= ($urandom_range(0, 99) < 70);
        endcase
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    gemm_cfg_t phases [$];
    gemm_cfg_t c;
    gemm_out_t z;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg = '{0, 0, 5'd16, 5'd16, 5'd16, 16'h0100, 16'h0100};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    load_cfg('{0, 0, 5'd1, 5'd1, 5'd1, 16'h0100, 16'h0100});
    z = '0;
    rows.insert(rows.size(), '{mk_req(REQ_WR_A, 0, 0, 16'h7fff), 1, '{REQ_WR_A, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_WR_B, 0, 0, 16'h8000), 1, '{REQ_WR_B, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_WR_C, 0, 0, 16'h0100), 1, '{REQ_WR_C, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_RD_C, 0, 0, 16'hffff), 1, '{REQ_RD_C, 16'h0100}});
    rows.insert(rows.size(),
                '{mk_req(REQ_COMPUTE, 15, 15, 16'h0), 1, '{REQ_COMPUTE, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_RD_C, 0, 0, 16'h0), 0, z});
    rows.insert(rows.size(), '{mk_req(REQ_WR_C, 15, 15, 16'h8000), 1, '{REQ_WR_C, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_RD_C, 15, 15, 16'h0), 1, '{REQ_RD_C, 16'h8000}});
    rows.insert(rows.size(), '{mk_req(REQ_WR_C, 15, 0, 16'h7fff), 1, '{REQ_WR_C, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_RD_C, 15, 0, 16'h0), 1, '{REQ_RD_C, 16'h7fff}});
    rows.insert(rows.size(), '{mk_req(REQ_WR_A, 15, 15, 16'hffff), 1, '{REQ_WR_A, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_WR_B, 0, 15, 16'h0001), 1, '{REQ_WR_B, 16'h0}});
    rows.insert(rows.size(),
                '{mk_req(REQ_UNUSED_5, 3, 4, 16'h1234), 1, '{REQ_UNUSED_5, 16'h0}});
    rows.insert(rows.size(),
                '{mk_req(REQ_UNUSED_6, 0, 0, 16'hffff), 1, '{REQ_UNUSED_6, 16'h0}});
    rows.insert(rows.size(),
                '{mk_req(REQ_UNUSED_7, 15, 15, 16'h8000), 1, '{REQ_UNUSED_7, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_WR_A, 0, 0, 16'h8000), 1, '{REQ_WR_A, 16'h0}});
    rows.insert(rows.size(),
                '{mk_req(REQ_COMPUTE, 0, 0, 16'h0), 1, '{REQ_COMPUTE, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_RD_C, 0, 0, 16'h0), 0, z});
    rows.insert(rows.size(), '{mk_req(REQ_WR_A, 0, 0, 16'h0100), 1, '{REQ_WR_A, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_WR_B, 0, 0, 16'h0180), 1, '{REQ_WR_B, 16'h0}});
    rows.insert(rows.size(),
                '{mk_req(REQ_COMPUTE, 0, 0, 16'h0), 1, '{REQ_COMPUTE, 16'h0}});
    rows.insert(rows.size(), '{mk_req(REQ_RD_C, 0, 0, 16'h0), 0, z});
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].ack);
    drain();

    phases.insert(phases.size(), '{0, 0, 5'd2, 5'd3, 5'd4, 16'h0100, 16'h0100});
    phases.insert(phases.size(), '{1, 0, 5'd4, 5'd2, 5'd3, 16'h8000, 16'h0000});
    phases.insert(phases.size(), '{0, 1, 5'd3, 5'd3, 5'd2, 16'h7fff, 16'h8000});
    phases.insert(phases.size(), '{1, 1, 5'd16, 5'd2, 5'd2, 16'h0080, 16'h7fff});
    phases.insert(phases.size(), '{0, 0, 5'd1, 5'd1, 5'd20, 16'hff00, 16'hffff});
    phases.insert(phases.size(), '{0, 0, 5'd0, 5'd3, 5'd3, 16'h0100, 16'h0100});
    phases.insert(phases.size(), '{0, 1, 5'd3, 5'd0, 5'd3, 16'h0200, 16'h0100});
    phases.insert(phases.size(), '{1, 0, 5'd2, 5'd2, 5'd0, 16'h0100, 16'h0200});
    phases.insert(phases.size(), '{1, 1, 5'd1, 5'd31, 5'd1, 16'h0001, 16'h0100});
    phases.insert(phases.size(), '{0, 0, 5'd2, 5'd16, 5'd16, 16'h0010, 16'hff80});
    repeat (8) begin
      c.ta = 1'($urandom_range(0, 1));
      c.tb = 1'($urandom_range(0, 1));
      c.m = 5'($urandom_range(1, 5));
      c.n = 5'($urandom_range(1, 5));
      c.k = 5'($urandom_range(1, 5));
      c.alpha = 16'(($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 1024) - 512);
      c.beta = 16'(($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 1024) - 512);
      phases.insert(phases.size(), c);
    end

    foreach (phases[p]) begin
      load_cfg(phases[p]);
      repeat (ITEMS_PER_PHASE) random_item();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending_acks.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
